// File: rtl/dlkt_pkg.sv
// dlkt_pkg: shared constants, request and status codes, and types
// for the device link key table.
// No dependencies; used by dlkt_ctrl and device_link_key_table_unit.
`default_nettype none

package dlkt_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // field widths
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 48;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 2;

  // one table entry: address in the low bits, then key halves
  localparam int ENTRY_W = ADDR_W + 2 * KEY_W;

  // stream payload widths
  localparam int IN_DATA_W  = ADDR_W + 2 * KEY_W;
  localparam int OUT_BITS   = STATUS_W + 2 * KEY_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // request codes
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_HIT      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // memory access from the sequencer
  typedef struct packed {
    logic               re;
    logic [IDX_W-1:0]   raddr;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
  } ram_req_t;

  // finished result from the sequencer
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key_hi;
    logic [KEY_W-1:0]    key_lo;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/dlkt_ram.sv
// dlkt_ram: generic single-write, single-read synchronous RAM with
// a registered read port. No dependencies.
`default_nettype none

module dlkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/dlkt_ctrl.sv
// dlkt_ctrl: request sequencer for the link key table. Holds the request,
// the entry valid bits, scans the entry memory and commits the update.
// Depends on dlkt_pkg.
`default_nettype none

module dlkt_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request side
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire logic [dlkt_pkg::KIND_W-1:0]       req_kind,
  input  wire logic [dlkt_pkg::ADDR_W-1:0]       req_addr,
  input  wire logic [dlkt_pkg::KEY_W-1:0]        req_key_hi,
  input  wire logic [dlkt_pkg::KEY_W-1:0]        req_key_lo,
  // entry memory
  output dlkt_pkg::ram_req_t                     ram_req,
  input  wire logic [dlkt_pkg::ENTRY_W-1:0]      ram_rdata,
  // result side
  output dlkt_pkg::result_t                      res,
  input  wire logic                              res_ready
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // held request
  logic [dlkt_pkg::KIND_W-1:0] kind_r;
  logic [dlkt_pkg::ADDR_W-1:0] addr_r;
  logic [dlkt_pkg::KEY_W-1:0]  key_hi_r, key_lo_r;

  // scan bookkeeping
  logic [dlkt_pkg::IDX_W-1:0]  issue_idx_r, issue_idx_nxt;
  logic                        issue_on_r, issue_on_nxt;
  logic                        pend_r, pend_nxt;
  logic [dlkt_pkg::IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic                        hit_r, hit_nxt;
  logic [dlkt_pkg::IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic                        free_r, free_nxt;
  logic [dlkt_pkg::IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [dlkt_pkg::KEY_W-1:0]  hit_hi_r, hit_hi_nxt;
  logic [dlkt_pkg::KEY_W-1:0]  hit_lo_r, hit_lo_nxt;

  // entry valid bits
  logic [dlkt_pkg::TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  logic                        accept;
  logic                        commit;
  logic                        match;
  logic [dlkt_pkg::ADDR_W-1:0] rd_addr;
  logic [dlkt_pkg::KEY_W-1:0]  rd_hi, rd_lo;

  assign req_ready = (state_r == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign commit    = (state_r == S_COMMIT) && res_ready;

  // unpack the entry read back from memory
  assign rd_addr = ram_rdata[dlkt_pkg::ADDR_W-1:0];
  assign rd_hi   = ram_rdata[dlkt_pkg::ADDR_W +: dlkt_pkg::KEY_W];
  assign rd_lo   = ram_rdata[dlkt_pkg::ADDR_W + dlkt_pkg::KEY_W +: dlkt_pkg::KEY_W];
  assign match   = pend_r && valid_r[pend_idx_r] && (rd_addr == addr_r);

  // scan and commit sequencing
  always_comb begin
    state_nxt     = state_r;
    issue_idx_nxt = issue_idx_r;
    issue_on_nxt  = issue_on_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = issue_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    hit_hi_nxt    = hit_hi_r;
    hit_lo_nxt    = hit_lo_r;
    valid_nxt     = valid_r;

    ram_req       = '0;
    res           = '0;
    res.status    = dlkt_pkg::ST_MISS;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt     = S_SCAN;
          issue_idx_nxt = '0;
          issue_on_nxt  = 1'b1;
          hit_nxt       = 1'b0;
          free_nxt      = 1'b0;
        end
      end
      S_SCAN: begin
        // read one entry per cycle
        ram_req.re    = issue_on_r;
        ram_req.raddr = issue_idx_r;
        pend_nxt      = issue_on_r;
        if (issue_on_r) begin
          if (issue_idx_r == dlkt_pkg::LAST_IDX) begin
            issue_on_nxt = 1'b0;
          end else begin
            issue_idx_nxt = issue_idx_r + 1'b1;
          end
        end
        // compare the entry that came back
        if (pend_r) begin
          if (match) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = pend_idx_r;
            hit_hi_nxt  = rd_hi;
            hit_lo_nxt  = rd_lo;
          end
          if (!valid_r[pend_idx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pend_idx_r;
          end
          if (pend_idx_r == dlkt_pkg::LAST_IDX) begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        res.valid = 1'b1;
        case (kind_r)
          dlkt_pkg::KIND_GET: begin
            if (hit_r) begin
              res.status = dlkt_pkg::ST_HIT;
              res.key_hi = hit_hi_r;
              res.key_lo = hit_lo_r;
            end
          end
          dlkt_pkg::KIND_PUT: begin
            ram_req.wdata = {key_lo_r, key_hi_r, addr_r};
            if (hit_r) begin
              res.status    = dlkt_pkg::ST_HIT;
              ram_req.we    = commit;
              ram_req.waddr = hit_idx_r;
            end else if (free_r) begin
              res.status    = dlkt_pkg::ST_INSERTED;
              ram_req.we    = commit;
              ram_req.waddr = free_idx_r;
              if (commit) begin
                valid_nxt[free_idx_r] = 1'b1;
              end
            end else begin
              res.status = dlkt_pkg::ST_FULL;
            end
          end
          dlkt_pkg::KIND_DELETE: begin
            if (hit_r) begin
              res.status = dlkt_pkg::ST_HIT;
              if (commit) begin
                valid_nxt[hit_idx_r] = 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      issue_on_r <= 1'b0;
      pend_r     <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      issue_on_r <= issue_on_nxt;
      pend_r     <= pend_nxt;
      hit_r      <= hit_nxt;
      free_r     <= free_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    issue_idx_r <= issue_idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    hit_hi_r    <= hit_hi_nxt;
    hit_lo_r    <= hit_lo_nxt;
    if (accept) begin
      kind_r   <= req_kind;
      addr_r   <= req_addr;
      key_hi_r <= req_key_hi;
      key_lo_r <= req_key_lo;
    end
  end

  // memory is written only when a result leaves
  a_write_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> commit)
    else $error("entry write outside commit");

  // a recorded hit always points at a live entry
  a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_r && state_r != S_IDLE) |-> valid_r[hit_idx_r])
    else $error("hit on an invalid entry");

  // a recorded free slot is still free until commit
  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r && state_r != S_IDLE) |-> !valid_r[free_idx_r])
    else $error("free slot already in use");

  // valid bits change only on a committed item
  a_valid_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(commit) |-> $stable(valid_r))
    else $error("valid bits changed without commit");

endmodule

`default_nettype wire

// File: rtl/device_link_key_table_unit.sv
// Device link key table: associative store of 16 entries mapping 48-bit
// device addresses to 128-bit link keys.
//
// in_*: one request item per handshake (tvalid and tready high). in_tuser
// carries the request kind (0 get, 1 put, 2 delete); in_tdata carries the
// address and the two key halves. out_*: exactly one result item per
// request, in request order, with a status code and, on a get hit, the key.
//
// Flow: a request is taken only while the sequencer is idle. It then
// reads the entry memory once per entry over its single read port,
// waits for the last read to return and commits the update; only then
// is the sequencer idle again and ready to accept the next request.
// The result sits in an output register; a new request is accepted while
// it waits. If the receiver stalls, the next item stops at its commit step
// until the output register empties; nothing is dropped.
//
// Reset (rst_n low, synchronous) clears all entry valid bits at once: the
// table is empty and ready on the first cycle after reset.
// Depends on dlkt_pkg, dlkt_ram and dlkt_ctrl.
`default_nettype none

module device_link_key_table_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request channel
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [47:0] device_address, [111:48] key_upper, [175:112] key_lower
  input  wire logic [dlkt_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] kind
  input  wire logic [dlkt_pkg::KIND_W-1:0]         in_tuser,
  // result channel
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [1:0] status, [65:2] found_key_upper, [129:66] found_key_lower,
  // [135:130] zero
  output logic      [dlkt_pkg::OUT_DATA_W-1:0]     out_tdata
);

  dlkt_pkg::ram_req_t                ram_req;
  dlkt_pkg::result_t                 res;
  logic [dlkt_pkg::ENTRY_W-1:0]      ram_rdata;
  logic                              res_ready;
  logic                              out_valid_r;
  logic [dlkt_pkg::OUT_DATA_W-1:0]   out_data_r;

  // sequencer
  dlkt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_kind   (in_tuser),
    .req_addr   (in_tdata[dlkt_pkg::ADDR_W-1:0]),
    .req_key_hi (in_tdata[dlkt_pkg::ADDR_W +: dlkt_pkg::KEY_W]),
    .req_key_lo (in_tdata[dlkt_pkg::ADDR_W + dlkt_pkg::KEY_W +: dlkt_pkg::KEY_W]),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .res        (res),
    .res_ready  (res_ready)
  );

  // entry memory: address and key per slot
  dlkt_ram #(
    .WIDTH (dlkt_pkg::ENTRY_W),
    .DEPTH (dlkt_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_data_r <= dlkt_pkg::OUT_DATA_W'({res.key_lo, res.key_hi, res.status});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
